// ===== src/chpt_pkg.sv =====
// Shared types and constants for the chained hash pair table.
// No dependencies; imported by every module of the block.
`default_nettype none
package chpt_pkg;

   typedef enum logic [2:0] {
      CMD_ADD        = 3'd0,
      CMD_REMOVE_KEY = 3'd1,
      CMD_REMOVE_PAIR= 3'd2,
      CMD_HAS_KEY    = 3'd3,
      CMD_HAS_PAIR   = 3'd4,
      CMD_COUNT_KEY  = 3'd5,
      CMD_GET        = 3'd6,
      CMD_UNUSED     = 3'd7
   } cmd_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] key_value;
      logic [31:0] data_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_data;
      logic [8:0]  match_count;
      logic [8:0]  stored_pairs;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HEAD,
      ST_READ,
      ST_CHECK,
      ST_FREE,
      ST_COMMIT,
      ST_LINK,
      ST_DONE
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic head_read;
      logic node_read;
      logic node_eval;
      logic free_step;
      logic commit;
      logic link;
      logic finish;
   } ctl_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic clear_done;
      logic chain_end;
      logic stop_walk;
      logic free_done;
      logic do_alloc;
      logic do_unlink;
   } sts_type;

endpackage
`default_nettype wire

// ===== src/chpt_ctrl.sv =====
// Controller state machine of the chained hash pair table.
// Depends on chpt_pkg.
`default_nettype none
module chpt_ctrl
   import chpt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_fire,
   input  wire logic    rsp_busy,
   input  wire sts_type sts,
   output ctl_type      ctl,
   output logic         req_ready
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (sts.clear_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_fire) state_in = ST_HEAD;
         ST_HEAD:   state_in = ST_READ;
         ST_READ:   state_in = ST_CHECK;
         ST_CHECK: begin
            if (sts.stop_walk || sts.chain_end) begin
               if (sts.do_alloc) state_in = ST_FREE;
               else if (sts.do_unlink) state_in = ST_COMMIT;
               else state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_FREE:   if (sts.free_done) state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_LINK;
         ST_LINK:   state_in = ST_DONE;
         ST_DONE:   if (!rsp_busy) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR:  ctl.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.load_req = 1'b1;
         end
         ST_HEAD:   ctl.head_read = 1'b1;
         ST_READ:   ctl.node_read = 1'b1;
         ST_CHECK:  ctl.node_eval = 1'b1;
         ST_FREE:   ctl.free_step = 1'b1;
         ST_COMMIT: ctl.commit = 1'b1;
         ST_LINK:   ctl.link = 1'b1;
         ST_DONE:   ctl.finish = !rsp_busy;
         default:   ctl = '0;
      endcase
   end

endmodule
`default_nettype wire

// ===== src/chpt_datapath.sv =====
// Datapath of the chained hash pair table: bucket heads, node pool, walk state.
// Depends on chpt_pkg; driven by chpt_ctrl.
`default_nettype none
module chpt_datapath
   import chpt_pkg::*;
#(
   parameter int BUCKETS  = 128,
   parameter int CAPACITY = 256
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire ctl_type ctl,
   output sts_type      sts,
   output rsp_type      result
);

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int PW = $clog2(CAPACITY + 1);
   localparam logic [PW-1:0] NIL = PW'(CAPACITY);
   localparam int CLEARS = (BUCKETS > CAPACITY) ? BUCKETS : CAPACITY;
   localparam int CW = $clog2(CLEARS + 1);

   // Heads hold a node pointer (NIL for empty). Node arrays are memories.
   logic [PW-1:0] head_mem [BUCKETS];
   logic [31:0]   key_mem  [CAPACITY];
   logic [31:0]   data_mem [CAPACITY];
   logic [PW-1:0] link_mem [CAPACITY];
   logic          used_mem [CAPACITY];

   req_type       req_ff;
   logic [BW-1:0] bucket_ff;
   logic [PW-1:0] cur_ff, prev_ff, tail_ff, found_ff, found_prev_ff, succ_ff;
   logic [PW-1:0] steps_ff, count_ff, total_ff, scan_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [31:0]   rd_key_ff, rd_data_ff, fdata_ff;
   logic [PW-1:0] rd_link_ff;
   logic          rd_used_ff, used_rd_ff;
   logic          found_ok_ff, full_ff;
   logic [CW-1:0] clr_ff;

   logic [BW-1:0] bucket_w;
   logic          key_eq, pair_eq, hit, is_pair_cmd, is_count, want_stop;
   logic [PW-1:0] next_ptr;
   cmd_type       cmd;

   assign cmd = cmd_type'(req_ff.command);
   if (BUCKETS > 1) begin : g_bkt
      assign bucket_w = BW'(req_data.key_value % BUCKETS);
   end else begin : g_bkt1
      assign bucket_w = '0;
   end

   assign is_pair_cmd = (cmd == CMD_ADD) || (cmd == CMD_REMOVE_PAIR) || (cmd == CMD_HAS_PAIR);
   assign is_count    = (cmd == CMD_COUNT_KEY);
   assign key_eq  = (rd_key_ff == req_ff.key_value);
   assign pair_eq = key_eq && (!is_pair_cmd || rd_data_ff == req_ff.data_value);
   assign hit     = (cur_ff != NIL) && pair_eq;
   assign next_ptr = rd_used_ff ? rd_link_ff : NIL;
   assign want_stop = hit && !is_count;

   // Walk evaluation: cur_ff is the node whose contents sit in rd_*_ff.
   assign sts.chain_end  = (cur_ff == NIL) || (steps_ff >= PW'(CAPACITY - 1))
                           || (next_ptr == NIL);
   assign sts.stop_walk  = want_stop || (cur_ff == NIL);
   assign sts.clear_done = (clr_ff == CW'(CLEARS - 1));
   assign sts.free_done  = !used_rd_ff || (scan_ff == NIL);
   assign sts.do_alloc   = (cmd == CMD_ADD) && !want_stop && (total_ff != NIL);
   assign sts.do_unlink  = want_stop &&
                           (cmd == CMD_REMOVE_KEY || cmd == CMD_REMOVE_PAIR);

   // The head pointer is read into rd_ptr_ff first; the node is read from it in the next cycle.
   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         req_ff    <= req_data;
         bucket_ff <= bucket_w;
      end
      if (ctl.head_read) rd_ptr_ff <= head_mem[bucket_ff];
      else if (ctl.node_eval) rd_ptr_ff <= next_ptr;
      if (ctl.node_read) cur_ff <= rd_ptr_ff;
   end

   // Node memory read, registered.
   logic [NW-1:0] rd_addr;
   logic [NW-1:0] scan_idx;
   assign rd_addr  = rd_ptr_ff[NW-1:0];
   assign scan_idx = scan_ff[NW-1:0];

   always_ff @(posedge clock) begin
      if (ctl.node_read) begin
         rd_key_ff  <= key_mem[rd_addr];
         rd_data_ff <= data_mem[rd_addr];
         rd_link_ff <= link_mem[rd_addr];
         rd_used_ff <= used_mem[rd_addr];
      end
      if (ctl.load_req) used_rd_ff <= 1'b1;
      else if (ctl.free_step) used_rd_ff <= used_mem[scan_idx];
   end

   // Bookkeeping registers of one walk.
   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         steps_ff <= '0;
         count_ff <= '0;
         prev_ff  <= NIL;
         tail_ff  <= NIL;
         found_ok_ff <= 1'b0;
         full_ff  <= (total_ff == NIL);
         scan_ff  <= '0;
      end
      if (ctl.node_eval && cur_ff != NIL) begin
         steps_ff <= steps_ff + 1'b1;
         tail_ff  <= cur_ff;
         if (is_count && key_eq) count_ff <= count_ff + 1'b1;
         if (want_stop) begin
            found_ok_ff   <= 1'b1;
            found_ff      <= cur_ff;
            found_prev_ff <= prev_ff;
            succ_ff       <= next_ptr;
            fdata_ff      <= rd_data_ff;
         end else begin
            prev_ff <= cur_ff;
         end
      end
      // The free search reads one flag a cycle; the lowest clear one wins.
      if (ctl.free_step && used_rd_ff && scan_ff != NIL) begin
         scan_ff <= scan_ff + 1'b1;
      end
   end

   // The free scan is one step behind its read, so the chosen index is scan-1.
   logic [PW-1:0] alloc_idx;
   assign alloc_idx = scan_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (ctl.commit) begin
         if (cmd == CMD_ADD) begin
            total_ff <= total_ff + 1'b1;
         end else begin
            total_ff <= total_ff - 1'b1;
         end
      end
   end

   // Memory writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (ctl.clear_step) begin
         if (clr_ff < CW'(BUCKETS)) head_mem[clr_ff[BW-1:0]] <= NIL;
         if (clr_ff < CW'(CAPACITY)) used_mem[clr_ff[NW-1:0]] <= 1'b0;
         clr_ff <= clr_ff + 1'b1;
      end
      if (ctl.commit) begin
         if (cmd == CMD_ADD) begin
            key_mem[alloc_idx[NW-1:0]]  <= req_ff.key_value;
            data_mem[alloc_idx[NW-1:0]] <= req_ff.data_value;
            link_mem[alloc_idx[NW-1:0]] <= NIL;
            used_mem[alloc_idx[NW-1:0]] <= 1'b1;
         end else begin
            used_mem[found_ff[NW-1:0]] <= 1'b0;
         end
      end
      if (ctl.link) begin
         if (cmd == CMD_ADD) begin
            if (tail_ff != NIL) link_mem[tail_ff[NW-1:0]] <= alloc_idx;
            else head_mem[bucket_ff] <= alloc_idx;
         end else begin
            if (found_prev_ff != NIL) link_mem[found_prev_ff[NW-1:0]] <= succ_ff;
            else head_mem[bucket_ff] <= succ_ff;
         end
      end
   end

   // Result assembly.
   always_comb begin
      result = '0;
      result.stored_pairs = 9'(total_ff);
      case (cmd)
         CMD_ADD: begin
            if (found_ok_ff) result.status = STATUS_NOTFOUND;
            else if (full_ff) result.status = STATUS_FULL;
            else result.status = STATUS_OK;
         end
         CMD_COUNT_KEY: begin
            result.status = STATUS_OK;
            result.match_count = 9'(count_ff);
         end
         CMD_GET: begin
            result.status = found_ok_ff ? STATUS_OK : STATUS_NOTFOUND;
            result.found_data = found_ok_ff ? fdata_ff : 32'd0;
         end
         CMD_REMOVE_KEY, CMD_REMOVE_PAIR, CMD_HAS_KEY, CMD_HAS_PAIR:
            result.status = found_ok_ff ? STATUS_OK : STATUS_NOTFOUND;
         default: result.status = STATUS_NOTFOUND;
      endcase
   end

endmodule
`default_nettype wire

// ===== src/chained_hash_pair_table_unit.sv =====
// Chained hash pair table: a hash multimap over a fixed node pool.
// Steps: the key's bucket head is read, then each chain node is read and checked in turn;
// a remove that hits then frees and unlinks its node, an add scans for a free node and links it.
// One item at a time: a new one is taken only after the last result is registered; a stalled result holds the next.
// Reset: synchronous; the bucket heads and in-use flags are cleared by a pass over
// max(BUCKETS, CAPACITY) entries during which no item is accepted.
`default_nettype none
module chained_hash_pair_table_unit
   import chpt_pkg::*;
#(
   parameter int BUCKETS  = 128,
   parameter int CAPACITY = 256
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   ctl_type ctl;
   sts_type sts;
   rsp_type result;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    rsp_busy;

   assign rsp_busy = rsp_valid_ff && !rsp_ready;

   chpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_valid && req_ready),
      .rsp_busy  (rsp_busy),
      .sts       (sts),
      .ctl       (ctl),
      .req_ready (req_ready)
   );

   chpt_datapath #(.BUCKETS(BUCKETS), .CAPACITY(CAPACITY)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctl      (ctl),
      .sts      (sts),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctl.finish) rsp_data_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result changed while stalled");
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(ctl.commit && ctl.finish))
      else $error("commit and finish overlap");
   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.stored_pairs <= 9'(CAPACITY))
      else $error("pair count beyond capacity");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for the chained hash pair table: random and directed requests
// with a behavioural multimap predictor. Depends on chpt_pkg and the unit.
`timescale 1ns / 100ps
module testbench;
   import chpt_pkg::*;

   localparam int BUCKETS  = 128;
   localparam int CAPACITY = 256;
   localparam int NIL      = CAPACITY;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   chained_hash_pair_table_unit #(.BUCKETS(BUCKETS), .CAPACITY(CAPACITY)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   int          head_of[BUCKETS];
   logic [31:0] pool_key[CAPACITY];
   logic [31:0] pool_data[CAPACITY];
   int          pool_link[CAPACITY];
   bit          pool_used[CAPACITY];
   int          pair_count;

   req_type pending_items[$];
   rsp_type expected_rsps[$];
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      mismatches = 0;
   logic [31:0] key_pool[8];
   logic [31:0] data_pool[4];

   function automatic int next_node(int n);
      if (n >= NIL || !pool_used[n]) return NIL;
      return pool_link[n];
   endfunction

   // Returns the first matching node and its predecessor in prev.
   function automatic int find_pair(int b, logic [31:0] k, bit by_pair, logic [31:0] d,
                                    output int prev);
      int p, n, steps;
      p = NIL; n = head_of[b]; steps = 0;
      while (n < NIL && steps < CAPACITY) begin
         if (pool_key[n] == k && (!by_pair || pool_data[n] == d)) begin
            prev = p;
            return n;
         end
         p = n; n = next_node(n); steps++;
      end
      prev = p;
      return NIL;
   endfunction

   function automatic rsp_type apply_request(req_type rq);
      rsp_type r;
      int b, n, prev, i, steps;
      r = '0;
      r.status = STATUS_NOTFOUND;
      b = rq.key_value % BUCKETS;
      case (cmd_type'(rq.command))
         CMD_ADD: begin
            n = find_pair(b, rq.key_value, 1, rq.data_value, prev);
            if (n == NIL) begin
               for (i = 0; i < CAPACITY && pool_used[i]; i++) ;
               if (i >= CAPACITY) r.status = STATUS_FULL;
               else begin
                  prev = NIL; n = head_of[b]; steps = 0;
                  while (n < NIL && steps < CAPACITY) begin
                     prev = n; n = next_node(n); steps++;
                  end
                  pool_key[i] = rq.key_value;
                  pool_data[i] = rq.data_value;
                  pool_link[i] = NIL;
                  pool_used[i] = 1;
                  if (prev < NIL) pool_link[prev] = i;
                  else head_of[b] = i;
                  pair_count++;
                  r.status = STATUS_OK;
               end
            end
         end
         CMD_REMOVE_KEY, CMD_REMOVE_PAIR: begin
            n = find_pair(b, rq.key_value, rq.command == CMD_REMOVE_PAIR,
                          rq.data_value, prev);
            if (n < NIL) begin
               if (prev < NIL) pool_link[prev] = next_node(n);
               else head_of[b] = next_node(n);
               pool_used[n] = 0;
               if (pair_count > 0) pair_count--;
               r.status = STATUS_OK;
            end
         end
         CMD_HAS_KEY, CMD_HAS_PAIR: begin
            n = find_pair(b, rq.key_value, rq.command == CMD_HAS_PAIR,
                          rq.data_value, prev);
            if (n < NIL) r.status = STATUS_OK;
         end
         CMD_COUNT_KEY: begin
            n = head_of[b]; steps = 0;
            while (n < NIL && steps < CAPACITY) begin
               if (pool_key[n] == rq.key_value) r.match_count++;
               n = next_node(n); steps++;
            end
            r.status = STATUS_OK;
         end
         CMD_GET: begin
            n = find_pair(b, rq.key_value, 0, 0, prev);
            if (n < NIL) begin
               r.found_data = pool_data[n];
               r.status = STATUS_OK;
            end
         end
         default: ;
      endcase
      r.stored_pairs = pair_count[8:0];
      return r;
   endfunction

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_rsps.push_back(apply_request(req_data));
         end
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               exp_r = expected_rsps.pop_front();
               if (rsp_data !== exp_r) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p, got %p", exp_r, rsp_data);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic req_type make_item(cmd_type c, logic [31:0] k, logic [31:0] d);
      req_type q;
      q.command = c; q.key_value = k; q.data_value = d;
      return q;
   endfunction

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   // Mostly keys from a small set that share few buckets, so chains grow long.
   function automatic req_type random_item();
      logic [31:0] k, d;
      int sel;
      sel = $urandom_range(99);
      k = (sel < 85) ? key_pool[$urandom_range(7)] : $urandom();
      d = ($urandom_range(99) < 80) ? data_pool[$urandom_range(3)] : $urandom();
      sel = $urandom_range(99);
      if (sel < 35) return make_item(CMD_ADD, k, d);
      if (sel < 97) return make_item(cmd_type'($urandom_range(1, 6)), k, d);
      return make_item(CMD_UNUSED, k, d);
   endfunction

   initial begin
      int phase, i;
      for (i = 0; i < BUCKETS; i++) head_of[i] = NIL;
      for (i = 0; i < CAPACITY; i++) begin
         pool_used[i] = 0; pool_link[i] = NIL;
         pool_key[i] = '0; pool_data[i] = '0;
      end
      pair_count = 0;
      for (i = 0; i < 8; i++)
         key_pool[i] = (i < 4) ? ($urandom() & 32'hffff_ff80) | 32'd5 : $urandom();
      key_pool[0] = 32'hffff_ffff;
      key_pool[1] = 32'h0000_007f;
      for (i = 0; i < 4; i++) data_pool[i] = $urandom();
      data_pool[0] = 32'h0;
      data_pool[1] = 32'hffff_ffff;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, duplicate add, misses, count of zero, unused code.
      pending_items.push_back(make_item(CMD_GET, 32'h0, 32'h0));
      pending_items.push_back(make_item(CMD_REMOVE_KEY, 32'h0, 32'h0));
      pending_items.push_back(make_item(CMD_COUNT_KEY, 32'h0, 32'h0));
      pending_items.push_back(make_item(CMD_ADD, 32'h0, 32'h0));
      pending_items.push_back(make_item(CMD_ADD, 32'h0, 32'h0));
      pending_items.push_back(make_item(CMD_ADD, 32'h0, 32'hffff_ffff));
      pending_items.push_back(make_item(CMD_ADD, 32'h80, 32'h1234_5678));
      pending_items.push_back(make_item(CMD_ADD, 32'hffff_ffff, 32'hffff_ffff));
      pending_items.push_back(make_item(CMD_HAS_KEY, 32'h0, 32'h0));
      pending_items.push_back(make_item(CMD_HAS_PAIR, 32'h0, 32'h5));
      pending_items.push_back(make_item(CMD_HAS_PAIR, 32'h80, 32'h1234_5678));
      pending_items.push_back(make_item(CMD_COUNT_KEY, 32'h0, 32'h0));
      pending_items.push_back(make_item(CMD_GET, 32'h0, 32'h0));
      pending_items.push_back(make_item(CMD_GET, 32'hffff_ffff, 32'h0));
      pending_items.push_back(make_item(CMD_REMOVE_KEY, 32'h0, 32'h0));
      pending_items.push_back(make_item(CMD_GET, 32'h0, 32'h0));
      pending_items.push_back(make_item(CMD_REMOVE_PAIR, 32'h80, 32'h0));
      pending_items.push_back(make_item(CMD_REMOVE_PAIR, 32'h80, 32'h1234_5678));
      pending_items.push_back(make_item(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff));
      wait_drained();

      // Fill the pool to capacity, then hit it when full.
      for (i = 0; i < CAPACITY; i++)
         pending_items.push_back(make_item(CMD_ADD, i * 3, $urandom()));
      pending_items.push_back(make_item(CMD_ADD, 32'h0, 32'h0));
      pending_items.push_back(make_item(CMD_ADD, 32'h3, 32'h0));
      pending_items.push_back(make_item(CMD_COUNT_KEY, 32'h0, 32'h0));
      for (i = 0; i < CAPACITY; i++)
         pending_items.push_back(make_item(CMD_REMOVE_KEY, i * 3, 32'h0));
      wait_drained();

      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            3: begin send_idle_pct = 37; recv_stall_pct = 37; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         for (i = 0; i < 250; i++) pending_items.push_back(random_item());
         wait_drained();
      end
      repeat (2000) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #100ms;
      $display("status: fail");
      $finish;
   end
endmodule

// ===== filelist.f =====
src/chpt_pkg.sv
src/chpt_ctrl.sv
src/chpt_datapath.sv
src/chained_hash_pair_table_unit.sv
dv/testbench.sv
